>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int PRIO_KEEP = (PRIO_BITS < 8) ? PRIO_BITS : 8;

    localparam logic [7:0] PRIO_MASK = 8'((9'd1 << PRIO_KEEP) - 9'd1);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
    } spq_entry_t;

    typedef struct packed {
        logic        enq;
        logic        deq;
        spq_entry_t  ent;
    } spq_ctrl_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] thread_id;
        logic [7:0]  priority_req;
    } spq_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        out_valid;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
    } spq_rsp_t;

endpackage

>>> rtl/spq_if.sv
`timescale 1ns / 1ps

interface spq_req_if;
    import spq_pkg::*;
    logic     valid;
    logic     ready;
    spq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;
    logic     valid;
    logic     ready;
    spq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/stable_priority_queue_unit.sv
`timescale 1ns / 1ps

// Stable priority queue: a sorted row of DEPTH cells, front (most urgent,
// smallest priority value) in cell 0. An enqueue lands behind every stored
// entry of equal or more urgent priority, so equal priorities leave in
// arrival order; a dequeue returns the front entry. Every request transfer
// yields exactly one response: status ok, empty (dequeue with nothing
// stored) or full (enqueue dropped). For each request,
// every cell compares its priority against the broadcast request and
// either holds, loads the request, or shifts from its neighbor. The
// response is registered in the cycle after the request transfer;
// a new request is taken in every cycle in which that register is empty or
// being drained, so the sustained rate is one request per cycle and only
// back-pressure on the response side stalls it. Stored entries need no
// reset; an occupancy counter marks which cells hold data.
module stable_priority_queue_unit
    import spq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    spq_req_if.sink         req,
    spq_rsp_if.source       rsp
);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    spq_rsp_t         res_reg;
    spq_rsp_t         res_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    spq_ctrl_t        ctrl;

    spq_entry_t       cell_ent   [DEPTH];
    logic             cell_after [DEPTH];
    spq_entry_t       left_ent   [DEPTH];
    spq_entry_t       right_ent  [DEPTH];
    logic             left_after [DEPTH];
    logic             own_valid  [DEPTH];

    // Take a new request whenever the response register is free or draining.
    assign req.ready = !res_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_full   = (occ_reg == OCC_W'(DEPTH));
    assign is_empty  = (occ_reg == '0);

    // Broadcast the request to all cells; a dropped or empty command does nothing.
    always_comb
    begin
        ctrl.enq      = accept && (req.data.cmd == CMD_ENQ) && !is_full;
        ctrl.deq      = accept && (req.data.cmd == CMD_DEQ) && !is_empty;
        ctrl.ent.id   = req.data.thread_id;
        ctrl.ent.prio = req.data.priority_req & PRIO_MASK;
    end

    // Neighbor wiring: cell 0 sees an always-after left side, the rear cell
    // holds its own entry on dequeue since it falls out of occupancy anyway.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            own_valid[i] = (OCC_W'(i) < occ_reg);
            if (i == 0)
            begin
                left_ent[i]   = ctrl.ent;
                left_after[i] = 1'b1;
            end
            else
            begin
                left_ent[i]   = cell_ent[i-1];
                left_after[i] = cell_after[i-1];
            end
            if (i == DEPTH - 1)
            begin
                right_ent[i] = cell_ent[i];
            end
            else
            begin
                right_ent[i] = cell_ent[i+1];
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .own_valid  (own_valid[g]),
            .left_after (left_after[g]),
            .left_ent   (left_ent[g]),
            .right_ent  (right_ent[g]),
            .ent        (cell_ent[g]),
            .after      (cell_after[g])
        );
    end

    // Occupancy and response generation.
    always_comb
    begin
        occ_next       = occ_reg;
        res_valid_next = res_valid_reg && !rsp.ready;
        res_next       = res_reg;
        if (ctrl.enq)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctrl.deq)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
        if (accept)
        begin
            res_valid_next         = 1'b1;
            res_next.status        = ST_OK;
            res_next.out_valid     = 1'b0;
            res_next.out_id        = '0;
            res_next.out_priority  = '0;
            if (req.data.cmd == CMD_DEQ)
            begin
                if (is_empty)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.out_valid    = 1'b1;
                    res_next.out_id       = cell_ent[0].id;
                    res_next.out_priority = cell_ent[0].prio;
                end
            end
            else if (is_full)
            begin
                res_next.status = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload register: no reset needed.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.data  = res_reg;

    // Every transfer in leaves a response waiting in the next cycle.
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("response missing after request transfer");

    // Accepted enqueue grows the queue by one.
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("occupancy did not grow on enqueue");

    // Occupancy never exceeds the row length.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    // Front two entries stay in priority order.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg >= OCC_W'(2)) |-> (cell_ent[0].prio <= cell_ent[1].prio))
        else $error("front entries out of order");

    // Empty and full responses never carry an entry.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != ST_OK)) |-> !res_reg.out_valid)
        else $error("error response carries an entry");

endmodule

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_ctrl_t  ctrl,
    input  logic       own_valid,
    input  logic       left_after,
    input  spq_entry_t left_ent,
    input  spq_entry_t right_ent,
    output spq_entry_t ent,
    output logic       after
);

    spq_entry_t ent_reg;
    spq_entry_t ent_next;

    // new entry goes behind this cell when this one is equal or more urgent
    assign after = own_valid && (ent_reg.prio <= ctrl.ent.prio);
    assign ent   = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.enq && !after)
        begin
            ent_next = left_after ? ctrl.ent : left_ent;
        end
        else if (ctrl.deq)
        begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule
